### design/rv32_integer_alu_execute_core_defines.svh
// ----------------------------------------------------------------------------
// RV32 ALU execute core assertion macros
// Shared assertion wrappers for the checker of the execute core.
// ----------------------------------------------------------------------------
`ifndef RV32_INTEGER_ALU_EXECUTE_CORE_DEFINES_SVH
`define RV32_INTEGER_ALU_EXECUTE_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RVALU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define RVALU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rvalu_pkg.sv
// ----------------------------------------------------------------------------
// RV32 ALU execute package
// Widths, data types and instruction encodings shared by the execute core
// and its channel interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rvalu_pkg;

    // Datapath and register file geometry.
    localparam int unsigned XLEN      = 32;
    localparam int unsigned NUM_REGS  = 32;
    localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
    localparam int unsigned IMM_W     = 12;
    localparam int unsigned SHAMT_W   = $clog2(XLEN);

    typedef logic [XLEN-1:0]      word_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [6:0]           opcode_t;
    typedef logic [2:0]           funct3_t;
    typedef logic [6:0]           funct7_t;

    // Major opcodes.
    localparam opcode_t OPC_OP     = 7'h33;
    localparam opcode_t OPC_OP_IMM = 7'h13;

    // funct7 values.
    localparam funct7_t F7_BASE   = 7'h00;
    localparam funct7_t F7_ALT    = 7'h20;
    localparam funct7_t F7_MULDIV = 7'h01;

    // funct3 values of the integer operations.
    localparam funct3_t F3_ADD  = 3'd0;
    localparam funct3_t F3_SLL  = 3'd1;
    localparam funct3_t F3_SLT  = 3'd2;
    localparam funct3_t F3_SLTU = 3'd3;
    localparam funct3_t F3_XOR  = 3'd4;
    localparam funct3_t F3_SRL  = 3'd5;
    localparam funct3_t F3_OR   = 3'd6;
    localparam funct3_t F3_AND  = 3'd7;

endpackage

`default_nettype wire

### design/rvalu_instr_if.sv
// ----------------------------------------------------------------------------
// RV32 ALU instruction channel
// Valid/ready channel that carries one instruction word per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rvalu_instr_if;

    logic             valid;
    logic             ready;
    rvalu_pkg::word_t instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);

endinterface

`default_nettype wire

### design/rvalu_result_if.sv
// ----------------------------------------------------------------------------
// RV32 ALU result channel
// Valid/ready channel that carries one register write-back item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rvalu_result_if;

    logic                valid;
    logic                ready;
    logic                write_enable;
    rvalu_pkg::reg_idx_t dest_index;
    rvalu_pkg::word_t    write_value;
    logic                recognized;

    modport source (
        output valid, output write_enable, output dest_index,
        output write_value, output recognized, input ready
    );
    modport sink (
        input valid, input write_enable, input dest_index,
        input write_value, input recognized, output ready
    );

endinterface

`default_nettype wire

### design/rv32_integer_alu_execute_core.sv
// ----------------------------------------------------------------------------
// RV32 integer ALU execute core
// Decodes and executes RV32I register and immediate integer operations except
// SRA/SRAI, plus MUL, on a 32-entry register file, one instruction per item.
// ----------------------------------------------------------------------------
// The core takes one instruction per clock cycle while the result side is
// not stalled, and returns one result item per instruction, in order. On the
// accepting edge the instruction is registered and both source registers are
// read from the register file memory; in the next cycle a single pass of
// decode, operand forwarding and ALU or multiplier logic produces the result,
// which is written back to the register file and loaded into the output
// register at the same edge. The write of the instruction just ahead is
// forwarded, so back-to-back dependent instructions run at full rate. The
// register file comes out of reset reading all zero through one valid flag
// per entry, so no clearing pass is needed. A stalled result register holds
// the execute stage, and the input stays ready while the execute stage can
// drain.
`timescale 1ns / 1ps
`default_nettype none

module rv32_integer_alu_execute_core (
    input  logic           clk,
    input  logic           rst_n,
    rvalu_instr_if.sink    instr,
    rvalu_result_if.source result
);
    import rvalu_pkg::*;

    // Handshake and stage control.
    logic     in_accept;
    logic     out_free;
    logic     ex_advance;
    logic     ex_vld_reg;
    word_t    ex_instr_reg;

    // Register file storage and registered read ports.
    word_t                rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0]  rf_vld_reg;
    word_t                rs1_data_reg;
    word_t                rs2_data_reg;
    logic                 rs1_vld_reg;
    logic                 rs2_vld_reg;

    // Last write-back, kept for forwarding.
    logic     wb_vld_reg;
    reg_idx_t wb_idx_reg;
    word_t    wb_data_reg;

    // Decoded fields of the executing instruction.
    opcode_t  opcode;
    reg_idx_t rd_idx;
    funct3_t  funct3;
    reg_idx_t rs1_idx;
    reg_idx_t rs2_idx;
    funct7_t  funct7;
    word_t    imm;
    logic     is_op;
    logic     is_op_imm;

    // Operands and unit outputs.
    word_t                op_a;
    word_t                rs2_val;
    word_t                op_b;
    logic [SHAMT_W-1:0]   shamt;
    word_t                sum;
    word_t                diff;
    word_t                mul_lo;
    word_t                base_res;
    word_t                res;

    // Next values of the output register.
    logic     rec_next;
    logic     we_next;
    word_t    value_next;

    // Output register.
    logic     out_vld_reg;
    logic     out_we_reg;
    reg_idx_t out_dest_reg;
    word_t    out_value_reg;
    logic     out_rec_reg;

    // Pipeline handshake.
    assign in_accept   = instr.valid && instr.ready;
    assign out_free    = !out_vld_reg || result.ready;
    assign ex_advance  = ex_vld_reg && out_free;
    assign instr.ready = !ex_vld_reg || out_free;

    // Execute stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_vld_reg <= 1'b0;
        end
        else if (instr.ready)
        begin
            ex_vld_reg <= instr.valid;
        end
    end

    // Instruction register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ex_instr_reg <= instr.instruction_word;
        end
    end

    // Register file: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (ex_advance && we_next)
        begin
            rf_mem[rd_idx] <= res;
        end
        if (in_accept)
        begin
            rs1_data_reg <= rf_mem[instr.instruction_word[19:15]];
            rs2_data_reg <= rf_mem[instr.instruction_word[24:20]];
        end
    end

    // Valid flags: an entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg  <= '0;
            rs1_vld_reg <= 1'b0;
            rs2_vld_reg <= 1'b0;
        end
        else
        begin
            if (ex_advance && we_next)
            begin
                rf_vld_reg[rd_idx] <= 1'b1;
            end
            if (in_accept)
            begin
                rs1_vld_reg <= rf_vld_reg[instr.instruction_word[19:15]];
                rs2_vld_reg <= rf_vld_reg[instr.instruction_word[24:20]];
            end
        end
    end

    // Forwarding register for the write made at the read edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_vld_reg <= 1'b0;
        end
        else if (ex_advance)
        begin
            wb_vld_reg <= we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_advance)
        begin
            wb_idx_reg  <= rd_idx;
            wb_data_reg <= res;
        end
    end

    // Field decode.
    assign opcode    = ex_instr_reg[6:0];
    assign rd_idx    = ex_instr_reg[11:7];
    assign funct3    = ex_instr_reg[14:12];
    assign rs1_idx   = ex_instr_reg[19:15];
    assign rs2_idx   = ex_instr_reg[24:20];
    assign funct7    = ex_instr_reg[31:25];
    assign imm       = {{(XLEN - IMM_W){ex_instr_reg[XLEN-1]}},
                        ex_instr_reg[XLEN-1 -: IMM_W]};
    assign is_op     = (opcode == OPC_OP);
    assign is_op_imm = (opcode == OPC_OP_IMM);

    // Source operands with forwarding of the latest write-back.
    always_comb
    begin
        if (wb_vld_reg && (wb_idx_reg == rs1_idx))
        begin
            op_a = wb_data_reg;
        end
        else
        begin
            op_a = rs1_vld_reg ? rs1_data_reg : '0;
        end
        if (wb_vld_reg && (wb_idx_reg == rs2_idx))
        begin
            rs2_val = wb_data_reg;
        end
        else
        begin
            rs2_val = rs2_vld_reg ? rs2_data_reg : '0;
        end
    end

    assign op_b  = is_op_imm ? imm : rs2_val;
    assign shamt = is_op_imm ? rs2_idx : rs2_val[SHAMT_W-1:0];

    // Arithmetic units.
    assign sum    = op_a + op_b;
    assign diff   = op_a - rs2_val;
    assign mul_lo = op_a * rs2_val;

    // Operation select shared by the register and immediate forms.
    always_comb
    begin
        case (funct3)
            F3_ADD:  base_res = sum;
            F3_SLL:  base_res = op_a << shamt;
            F3_SLT:  base_res = word_t'($signed(op_a) < $signed(op_b));
            F3_SLTU: base_res = word_t'(op_a < op_b);
            F3_XOR:  base_res = op_a ^ op_b;
            F3_SRL:  base_res = op_a >> shamt;
            F3_OR:   base_res = op_a | op_b;
            F3_AND:  base_res = op_a & op_b;
            default: base_res = '0;
        endcase
    end

    // Recognition and final result.
    always_comb
    begin
        rec_next = 1'b0;
        res      = base_res;
        if (is_op_imm)
        begin
            if ((funct3 == F3_SLL) || (funct3 == F3_SRL))
            begin
                rec_next = (funct7 == F7_BASE);
            end
            else
            begin
                rec_next = 1'b1;
            end
        end
        else if (is_op)
        begin
            if (funct7 == F7_BASE)
            begin
                rec_next = 1'b1;
            end
            else if ((funct7 == F7_ALT) && (funct3 == F3_ADD))
            begin
                rec_next = 1'b1;
                res      = diff;
            end
            else if ((funct7 == F7_MULDIV) && (funct3 == F3_ADD))
            begin
                rec_next = 1'b1;
                res      = mul_lo;
            end
        end
    end

    assign we_next    = rec_next && (rd_idx != '0);
    assign value_next = we_next ? res : '0;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= ex_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_advance)
        begin
            out_we_reg    <= we_next;
            out_dest_reg  <= rd_idx;
            out_value_reg <= value_next;
            out_rec_reg   <= rec_next;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.write_enable = out_we_reg;
    assign result.dest_index   = out_dest_reg;
    assign result.write_value  = out_value_reg;
    assign result.recognized   = out_rec_reg;

endmodule

`default_nettype wire

### design/rvalu_checker.sv
// ----------------------------------------------------------------------------
// RV32 ALU execute core checker
// Port-level checks of the execute core, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rv32_integer_alu_execute_core_defines.svh"

module rvalu_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                out_we,
    input  rvalu_pkg::reg_idx_t out_dest,
    input  rvalu_pkg::word_t    out_value,
    input  logic                out_rec
);
    import rvalu_pkg::*;

    // No result item is offered while reset is asserted.
    `RVALU_ASSERT_RST(a_no_out_in_reset, !rst_n |-> !out_valid, "result valid during reset")

    // With the result register empty the execute stage always drains.
    `RVALU_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

    // A write needs a recognized operation and a nonzero destination.
    `RVALU_ASSERT(a_we_legal, (out_valid && out_we) |-> (out_rec && (out_dest != '0)), "illegal write enable")

    // Nothing written means a zero write value.
    `RVALU_ASSERT(a_value_zero, (out_valid && !out_we) |-> (out_value == '0), "nonzero value without write")

    // A stalled result item holds.
    `RVALU_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_dest)), "stalled result changed")

endmodule

bind rv32_integer_alu_execute_core rvalu_checker u_rvalu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (instr.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_we    (result.write_enable),
    .out_dest  (result.dest_index),
    .out_value (result.write_value),
    .out_rec   (result.recognized)
);

`default_nettype wire

### sim/rv32_integer_alu_execute_core_checker.sv
// ----------------------------------------------------------------------------
// RV32 ALU execute core checker
// Watches the instruction and result channels, keeps a shadow register file,
// predicts the write-back of every accepted instruction and compares each
// accepted result item against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32_integer_alu_execute_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    rvalu_instr_if      instr,
    rvalu_result_if     result,
    output int unsigned error_count,
    output int unsigned pending_count
);
    import rvalu_pkg::*;

    // One predicted write-back item.
    typedef struct packed {
        logic     write_enable;
        reg_idx_t dest_index;
        word_t    write_value;
        logic     recognized;
    } writeback_t;

    word_t      shadow_regs [NUM_REGS];
    writeback_t writeback_queue [$];
    writeback_t want_wb;
    writeback_t next_wb;

    // Decode and execute one instruction against the shadow register file.
    function automatic writeback_t predict_writeback(input word_t iw);
        opcode_t    opc;
        funct3_t    f3;
        funct7_t    f7;
        reg_idx_t   rd;
        reg_idx_t   rs1;
        reg_idx_t   rs2;
        word_t      a;
        word_t      b;
        word_t      imm;
        word_t      res;
        logic       ok;
        writeback_t wb;
        opc = iw[6:0];
        rd  = iw[11:7];
        f3  = iw[14:12];
        rs1 = iw[19:15];
        rs2 = iw[24:20];
        f7  = iw[31:25];
        imm = {{(XLEN-IMM_W){iw[31]}}, iw[31:20]};
        a   = shadow_regs[rs1];
        b   = shadow_regs[rs2];
        res = '0;
        ok  = 1'b0;
        if (opc == OPC_OP_IMM)
        begin
            case (f3)
                F3_ADD:  begin res = a + imm; ok = 1'b1; end
                F3_SLT:  begin res = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0; ok = 1'b1; end
                F3_SLTU: begin res = (a < imm) ? 32'd1 : 32'd0; ok = 1'b1; end
                F3_XOR:  begin res = a ^ imm; ok = 1'b1; end
                F3_OR:   begin res = a | imm; ok = 1'b1; end
                F3_AND:  begin res = a & imm; ok = 1'b1; end
                F3_SLL:
                begin
                    if (f7 == F7_BASE)
                    begin
                        res = a << rs2;
                        ok  = 1'b1;
                    end
                end
                F3_SRL:
                begin
                    if (f7 == F7_BASE)
                    begin
                        res = a >> rs2;
                        ok  = 1'b1;
                    end
                end
                default: ok = 1'b0;
            endcase
        end
        else if (opc == OPC_OP)
        begin
            if (f7 == F7_BASE)
            begin
                ok = 1'b1;
                case (f3)
                    F3_ADD:  res = a + b;
                    F3_SLL:  res = a << b[SHAMT_W-1:0];
                    F3_SLT:  res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    F3_SLTU: res = (a < b) ? 32'd1 : 32'd0;
                    F3_XOR:  res = a ^ b;
                    F3_SRL:  res = a >> b[SHAMT_W-1:0];
                    F3_OR:   res = a | b;
                    F3_AND:  res = a & b;
                    default: res = '0;
                endcase
            end
            else if (f7 == F7_ALT && f3 == F3_ADD)
            begin
                res = a - b;
                ok  = 1'b1;
            end
            else if (f7 == F7_MULDIV && f3 == F3_ADD)
            begin
                // Only the low half of the product is kept.
                res = a * b;
                ok  = 1'b1;
            end
        end
        wb.recognized   = ok;
        wb.dest_index   = rd;
        wb.write_enable = ok && (rd != '0);
        wb.write_value  = wb.write_enable ? res : '0;
        return wb;
    endfunction

    // Compare results first, then predict, so a result never meets the
    // prediction of the instruction accepted on the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (shadow_regs[i])
                shadow_regs[i] = '0;
            writeback_queue.delete();
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (writeback_queue.size() == 0)
                begin
                    $error("result item arrived with no instruction outstanding");
                    error_count = error_count + 1;
                end
                else
                begin
                    want_wb = writeback_queue.pop_front();
                    if (result.write_enable !== want_wb.write_enable)
                    begin
                        $error("write_enable mismatch: expected %0d, got %0d",
                               want_wb.write_enable, result.write_enable);
                        error_count = error_count + 1;
                    end
                    if (result.dest_index !== want_wb.dest_index)
                    begin
                        $error("dest_index mismatch: expected %0d, got %0d",
                               want_wb.dest_index, result.dest_index);
                        error_count = error_count + 1;
                    end
                    if (result.write_value !== want_wb.write_value)
                    begin
                        $error("write_value mismatch: expected 0x%08h, got 0x%08h",
                               want_wb.write_value, result.write_value);
                        error_count = error_count + 1;
                    end
                    if (result.recognized !== want_wb.recognized)
                    begin
                        $error("recognized mismatch: expected %0d, got %0d",
                               want_wb.recognized, result.recognized);
                        error_count = error_count + 1;
                    end
                end
            end
            if (instr.valid && instr.ready)
            begin
                next_wb = predict_writeback(instr.instruction_word);
                if (next_wb.write_enable)
                    shadow_regs[next_wb.dest_index] = next_wb.write_value;
                writeback_queue.push_back(next_wb);
            end
            pending_count = writeback_queue.size();
        end
    end

endmodule

### sim/rv32_integer_alu_execute_core_tb.sv
// ----------------------------------------------------------------------------
// RV32 ALU execute core testbench
// Drives directed and random instruction streams into the execute core with
// bursty input and a stalling result side, and reports the checker verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32_integer_alu_execute_core_tb;

    import rvalu_pkg::*;

    localparam int unsigned NUM_ITEMS   = 1050;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_STALL  = 300;
    localparam int unsigned DRAIN_TAIL  = 8;

    // Receiver stall patterns.
    typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MASK} rx_mode_t;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned results_pending;
    int unsigned items_sent;
    int          burst_left;
    bit          long_stall_req;
    bit          stall_done;
    bit          drain_done;

    rvalu_instr_if  instr_ch ();
    rvalu_result_if result_ch ();

    rv32_integer_alu_execute_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    rv32_integer_alu_execute_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .instr         (instr_ch),
        .result        (result_ch),
        .error_count   (fail_count),
        .pending_count (results_pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Instruction encoders.
    function automatic word_t enc_reg_op(input funct7_t f7, input reg_idx_t rs2,
                                         input reg_idx_t rs1, input funct3_t f3,
                                         input reg_idx_t rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic word_t enc_imm_op(input logic [IMM_W-1:0] imm, input reg_idx_t rs1,
                                         input funct3_t f3, input reg_idx_t rd);
        return {imm, rs1, f3, rd, OPC_OP_IMM};
    endfunction

    // Register choice leans on a few low registers so results feed each other.
    function automatic reg_idx_t random_reg();
        if ($urandom_range(0, 2) == 0)
            return reg_idx_t'($urandom_range(0, NUM_REGS - 1));
        return reg_idx_t'($urandom_range(1, 7));
    endfunction

    function automatic reg_idx_t random_dest();
        if ($urandom_range(0, 15) == 0)
            return '0;
        return random_reg();
    endfunction

    function automatic logic [IMM_W-1:0] random_imm();
        case ($urandom_range(0, 7))
            0:       return 12'h000;
            1:       return 12'h7FF;
            2:       return 12'h800;
            3:       return 12'hFFF;
            default: return 12'($urandom());
        endcase
    endfunction

    function automatic word_t random_load_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // A supported operation with random operands.
    function automatic word_t random_valid_op();
        reg_idx_t rd;
        reg_idx_t rs1;
        reg_idx_t rs2;
        funct3_t  f3;
        rd  = random_dest();
        rs1 = random_reg();
        rs2 = random_reg();
        case ($urandom_range(0, 16))
            0, 1, 2, 3, 4, 5, 6, 7:
                return enc_reg_op(F7_BASE, rs2, rs1, funct3_t'($urandom_range(0, 7)), rd);
            8:  return enc_reg_op(F7_ALT, rs2, rs1, F3_ADD, rd);
            9:  return enc_reg_op(F7_MULDIV, rs2, rs1, F3_ADD, rd);
            10: return enc_imm_op(random_imm(), rs1, F3_ADD, rd);
            11: return enc_imm_op(random_imm(), rs1, F3_SLT, rd);
            12: return enc_imm_op(random_imm(), rs1, F3_SLTU, rd);
            13: return enc_imm_op(random_imm(), rs1, F3_XOR, rd);
            14: return enc_imm_op(random_imm(), rs1, F3_OR, rd);
            15: return enc_imm_op(random_imm(), rs1, F3_AND, rd);
            default:
            begin
                f3 = ($urandom_range(0, 1) == 0) ? F3_SLL : F3_SRL;
                return enc_imm_op({F7_BASE, rs2}, rs1, f3, rd);
            end
        endcase
    endfunction

    // Encodings close to supported ones, most of which must be rejected.
    function automatic word_t random_broken_op();
        reg_idx_t rd;
        reg_idx_t rs1;
        reg_idx_t rs2;
        funct7_t  f7;
        rd  = random_dest();
        rs1 = random_reg();
        rs2 = random_reg();
        f7  = funct7_t'($urandom_range(1, 127));
        case ($urandom_range(0, 4))
            0: return enc_reg_op(F7_ALT, rs2, rs1, F3_SRL, rd);
            1: return enc_imm_op({F7_ALT, rs2}, rs1, F3_SRL, rd);
            2: return enc_imm_op({f7, rs2}, rs1,
                                 ($urandom_range(0, 1) == 0) ? F3_SLL : F3_SRL, rd);
            3: return enc_reg_op(f7, rs2, rs1, funct3_t'($urandom_range(0, 7)), rd);
            default: return {f7, rs2, rs1, funct3_t'($urandom_range(0, 7)), rd,
                             opcode_t'($urandom_range(0, 127))};
        endcase
    endfunction

    // Offer one item and hold it until accepted; idle between bursts.
    task automatic send_instr(input word_t iw);
        if (burst_left <= 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 12);
        end
        instr_ch.valid            <= 1'b1;
        instr_ch.instruction_word <= iw;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        burst_left = burst_left - 1;
        items_sent = items_sent + 1;
        @(negedge clk);
    endtask

    // Build a full 32-bit value in rd from three chunks.
    task automatic send_load(input reg_idx_t rd, input word_t v);
        send_instr(enc_imm_op({1'b0, v[31:21]}, '0, F3_ADD, rd));
        send_instr(enc_imm_op({F7_BASE, 5'd11}, rd, F3_SLL, rd));
        send_instr(enc_imm_op({1'b0, v[20:10]}, rd, F3_OR, rd));
        send_instr(enc_imm_op({F7_BASE, 5'd10}, rd, F3_SLL, rd));
        send_instr(enc_imm_op({2'b00, v[9:0]}, rd, F3_OR, rd));
    endtask

    // Stop offering until every outstanding result item has come back.
    task automatic drain_results();
        instr_ch.valid <= 1'b0;
        burst_left = 0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    // Result side: rotating stall patterns, plus one long hold-off on request.
    initial
    begin : rx_stall
        rx_mode_t    mode;
        int          mode_left;
        logic [7:0]  mask;
        result_ch.ready = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        mask      = 8'hFF;
        forever
        begin
            @(negedge clk);
            if (long_stall_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(negedge clk);
                long_stall_req = 1'b0;
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                    mask      = 8'($urandom());
                end
                mode_left = mode_left - 1;
                case (mode)
                    RX_ALWAYS: result_ch.ready <= 1'b1;
                    RX_HALF:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_MASK:
                    begin
                        result_ch.ready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                    default:   result_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int unsigned sel;
        rst_n                     <= 1'b0;
        instr_ch.valid            = 1'b0;
        instr_ch.instruction_word = '0;
        items_sent                = 0;
        burst_left                = 0;
        long_stall_req            = 1'b0;
        stall_done                = 1'b0;
        drain_done                = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extreme operands, every operation, and the rejected forms.
        send_instr(enc_imm_op(12'hFFF, 5'd0, F3_ADD, 5'd1));          // x1 = all ones
        send_instr(enc_imm_op(12'h001, 5'd0, F3_ADD, 5'd2));
        send_instr(enc_imm_op({F7_BASE, 5'd31}, 5'd2, F3_SLL, 5'd2)); // x2 = sign bit
        send_instr(enc_imm_op(12'hFFF, 5'd2, F3_ADD, 5'd3));          // x3 = max positive
        send_instr(enc_reg_op(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd4));
        send_instr(enc_reg_op(F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd5));
        send_instr(enc_reg_op(F7_BASE, 5'd3, 5'd1, F3_AND, 5'd6));
        send_instr(enc_reg_op(F7_BASE, 5'd3, 5'd2, F3_OR, 5'd7));
        send_instr(enc_reg_op(F7_BASE, 5'd3, 5'd1, F3_XOR, 5'd8));
        send_instr(enc_reg_op(F7_BASE, 5'd1, 5'd1, F3_SLL, 5'd9));    // shift by low 5 bits
        send_instr(enc_reg_op(F7_BASE, 5'd1, 5'd1, F3_SRL, 5'd10));
        send_instr(enc_reg_op(F7_BASE, 5'd3, 5'd2, F3_SLT, 5'd11));
        send_instr(enc_reg_op(F7_BASE, 5'd3, 5'd2, F3_SLTU, 5'd12));
        send_instr(enc_reg_op(F7_MULDIV, 5'd3, 5'd3, F3_ADD, 5'd13));
        send_instr(enc_imm_op(12'h7FF, 5'd3, F3_ADD, 5'd14));
        send_instr(enc_imm_op(12'h800, 5'd1, F3_AND, 5'd15));
        send_instr(enc_imm_op(12'h800, 5'd0, F3_OR, 5'd16));
        send_instr(enc_imm_op(12'hFFF, 5'd3, F3_XOR, 5'd17));
        send_instr(enc_imm_op(12'hFFF, 5'd2, F3_SLT, 5'd18));
        send_instr(enc_imm_op(12'hFFF, 5'd1, F3_SLTU, 5'd19));        // immediate as unsigned
        send_instr(enc_imm_op({F7_BASE, 5'd31}, 5'd1, F3_SRL, 5'd20));
        send_instr(enc_reg_op(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd0));    // destination zero
        send_instr(enc_reg_op(F7_ALT, 5'd1, 5'd2, F3_SRL, 5'd21));    // arithmetic shift
        send_instr(enc_imm_op({F7_ALT, 5'd4}, 5'd2, F3_SRL, 5'd22));
        send_instr(enc_imm_op({F7_MULDIV, 5'd4}, 5'd1, F3_SLL, 5'd23));
        send_instr(32'hFFFF_FFFF);                                    // unknown opcode
        drain_results();

        // Random: mostly well-formed streams with random content.
        while (items_sent < NUM_ITEMS)
        begin
            if (!stall_done && items_sent >= 350)
            begin
                stall_done     = 1'b1;
                long_stall_req = 1'b1;
                burst_left     = LONG_STALL;
            end
            if (!drain_done && items_sent >= 700)
            begin
                drain_done = 1'b1;
                drain_results();
            end
            sel = $urandom_range(0, 99);
            if (sel < 8)
                send_load(reg_idx_t'($urandom_range(1, NUM_REGS - 1)), random_load_value());
            else if (sel < 78)
                send_instr(random_valid_op());
            else if (sel < 90)
                send_instr(random_broken_op());
            else
                send_instr($urandom());
        end

        drain_results();
        repeat (DRAIN_TAIL) @(negedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/rvalu_pkg.sv
design/rvalu_instr_if.sv
design/rvalu_result_if.sv
design/rv32_integer_alu_execute_core.sv
design/rvalu_checker.sv
sim/rv32_integer_alu_execute_core_checker.sv
sim/rv32_integer_alu_execute_core_tb.sv
